### rtl/tmp_pkg.sv
// shared types and constants of the trapezoid motion planner
`default_nettype none
package tmp_pkg;

   localparam int unsigned POS_WIDTH   = 32;
   localparam int unsigned CFG_WIDTH   = 24;
   localparam int unsigned DT_WIDTH    = 32;
   localparam int unsigned CSR_IDX_WIDTH = 2;

   localparam int unsigned MUL_M_WIDTH = 64;
   localparam int unsigned MUL_B_WIDTH = 32;
   localparam int unsigned MUL_P_WIDTH = MUL_M_WIDTH + MUL_B_WIDTH;

   localparam int unsigned SQRT_IN_WIDTH   = 64;
   localparam int unsigned SQRT_ROOT_WIDTH = SQRT_IN_WIDTH / 2;

   localparam int unsigned DIV_Q_WIDTH = 32;
   localparam int unsigned DIV_N_WIDTH = 2 * DIV_Q_WIDTH;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_RESET = 2'd1;
   localparam logic [1:0] FUNC_MOVE  = 2'd2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ACCEL  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPEED  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PERIOD = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FOLLOW = 2'd3;

   localparam logic [CFG_WIDTH-1:0] ACCEL_RESET  = 24'd100000;
   localparam logic [CFG_WIDTH-1:0] SPEED_RESET  = 24'd10000;
   localparam logic [DT_WIDTH-1:0]  PERIOD_RESET = 32'd858993;
   localparam logic [CFG_WIDTH-1:0] FOLLOW_RESET = 24'd0;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] measured_pos;
      logic signed [31:0] measured_vel;
      logic signed [31:0] target_pos;
   } tmp_req_type;

   typedef struct packed {
      logic signed [31:0] cmd_pos;
      logic signed [31:0] cmd_vel;
      logic               moving;
   } tmp_rsp_type;

endpackage
`default_nettype wire

### rtl/trapezoid_motion_planner_unit.sv
// trapezoid motion planner: sequencer around serial multiplier, root and divider
//
// req_valid / req_stall carry one item: tick, reset from measurement or move.
// rsp_valid / rsp_stall return one result beat per item: the commanded
// position, velocity and the moving flag after that item.
// csr_valid / csr_ready write one of four settings; csr_ready is always high
// and writes are meant to come while the planner is idle.
// A reset, move or unused item, or a tick while idle, goes straight to the result step.
// A tick while active runs up to five multiplies, at most one square root and
// at most one division through bit-serial units of 32 steps each.
// Items are taken one at a time; req_stall is high from acceptance until the
// result has gone into the output register.
// The output register holds a result while rsp_stall is high; a finished
// item waits for it to empty before the planner takes the next item.
// Synchronous reset restores the default settings, clears the planner state
// and leaves the planner idle with no result pending.
`default_nettype none
module trapezoid_motion_planner_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tmp_pkg::tmp_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tmp_pkg::tmp_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tmp_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [31:0]                         csr_data
);
   import tmp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIST, S_ADT, S_H2, S_AD, S_SQRT, S_RAMP,
      S_VDT, S_DIV, S_OUTV, S_MAG, S_POS, S_DONE
   } state_type;

   typedef enum logic [1:0] {MODE_IDLE, MODE_ACTIVE, MODE_SEEDED} mode_type;

   localparam logic signed [34:0] VEL_MAX = 35'sh0_7FFF_FFFF;
   localparam logic signed [34:0] VEL_MIN = -35'sh0_8000_0000;
   localparam logic signed [33:0] POS_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] POS_MIN = -34'sh0_8000_0000;

   state_type state_ff;
   mode_type  mode_ff;

   logic [CFG_WIDTH-1:0] accel_ff, speed_ff, follow_ff;
   logic [DT_WIDTH-1:0]  period_ff;

   logic signed [31:0] pos_ff, vel_ff, frac_ff, goal_ff, meas_ff;
   logic               rev_ff, land_ff;
   logic [56:0]        dmag_ff;
   logic signed [33:0] v_ff;
   logic [31:0]        h_ff, vstop_ff;
   logic [32:0]        step_ff;
   logic [63:0]        h2_ff;
   logic signed [27:0] whole_ff;

   tmp_rsp_type rsp_ff;
   logic        rsp_valid_ff;

   logic                   mul_start_ff, sqrt_start_ff, div_start_ff;
   logic [MUL_M_WIDTH-1:0] mul_m_ff;
   logic [MUL_B_WIDTH-1:0] mul_b_ff;
   logic [SQRT_IN_WIDTH-1:0] sqrt_x_ff;
   logic [DIV_N_WIDTH-1:0] div_n_ff;
   logic                   mul_done, sqrt_done, div_done;
   logic [MUL_P_WIDTH-1:0] mul_product;
   logic [SQRT_ROOT_WIDTH-1:0] sqrt_root;
   logic [DIV_Q_WIDTH-1:0] div_quotient;

   tmp_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start_ff), .op_m(mul_m_ff),
      .op_b(mul_b_ff), .done(mul_done), .product(mul_product)
   );

   tmp_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start_ff), .radicand(sqrt_x_ff),
      .done(sqrt_done), .root(sqrt_root)
   );

   tmp_div u_div (
      .clock(clock), .reset(reset), .start(div_start_ff), .dividend(div_n_ff),
      .divisor(period_ff), .done(div_done), .quotient(div_quotient)
   );

   // distance to goal
   logic signed [32:0] diff_in;
   logic signed [57:0] dist_in, ndist_in;
   logic [56:0]        dmag_in;
   logic signed [33:0] vel_ext, v_in;
   assign diff_in  = $signed({goal_ff[31], goal_ff}) - $signed({pos_ff[31], pos_ff});
   assign dist_in  = $signed({diff_in[32], diff_in, 24'd0})
                   - $signed({{26{frac_ff[31]}}, frac_ff});
   assign ndist_in = -dist_in;
   assign dmag_in  = dist_in[57] ? ndist_in[56:0] : dist_in[56:0];
   assign vel_ext  = {{2{vel_ff[31]}}, vel_ff};
   assign v_in     = dist_in[57] ? -vel_ext : vel_ext;

   // ramp step and half step
   logic [56:0] hsum_in, ssum_in;
   assign hsum_in = {1'b0, mul_product[55:0]} + 57'd16777216;
   assign ssum_in = {1'b0, mul_product[55:0]} + 57'd8388608;

   // radicand
   logic [89:0] rad_in;
   logic        big_in;
   assign rad_in = {1'b0, mul_product[95:7]} + {26'd0, h2_ff};
   assign big_in = |rad_in[89:64];

   // stopping envelope
   logic [32:0] s_in;
   assign s_in = {1'b0, sqrt_root} - {1'b0, h_ff};

   // ramp toward the cap
   logic [31:0]        spd_in, vdes_in;
   logic signed [35:0] vdes_s, v36, step36, up_in, dn_in, vr_in;
   logic               may_land_in;
   assign spd_in  = {speed_ff, 8'd0};
   assign vdes_in = (spd_in > vstop_ff) ? vstop_ff : spd_in;
   assign vdes_s  = $signed({4'd0, vdes_in});
   assign v36     = {{2{v_ff[33]}}, v_ff};
   assign step36  = $signed({3'd0, step_ff});
   assign up_in   = v36 + step36;
   assign dn_in   = v36 - step36;
   always_comb begin
      if (v36 < vdes_s) vr_in = (up_in > vdes_s) ? vdes_s : up_in;
      else vr_in = (dn_in < vdes_s) ? vdes_s : dn_in;
   end
   assign may_land_in = !vr_in[35] && (vr_in <= $signed({4'd0, vstop_ff}));

   // landing test
   logic land_in;
   assign land_in = {9'd0, mul_product[63:16]} >= dmag_ff;

   // signed velocity out
   logic signed [34:0] vs_in, abs_in;
   logic signed [31:0] velo_in;
   assign vs_in = rev_ff ? -{v_ff[33], v_ff} : {v_ff[33], v_ff};
   always_comb begin
      if (vs_in > VEL_MAX) velo_in = 32'sh7FFF_FFFF;
      else if (vs_in < VEL_MIN) velo_in = -32'sh8000_0000;
      else velo_in = vs_in[31:0];
   end
   assign abs_in = velo_in[31] ? -{{3{velo_in[31]}}, velo_in} : {{3{velo_in[31]}}, velo_in};

   // fraction update and whole steps
   logic [64:0]        isum_in;
   logic signed [50:0] fsx_in, inc51, fr_in, nfr_in, ws_in, ns_in, newfrac_in;
   logic signed [27:0] whole_in;
   assign isum_in = {1'b0, mul_product[63:0]} + 65'd32768;
   assign fsx_in  = {{19{frac_ff[31]}}, frac_ff};
   assign inc51   = $signed({2'd0, isum_in[64:16]});
   assign fr_in   = vel_ff[31] ? fsx_in - inc51 : fsx_in + inc51;
   assign nfr_in  = -fr_in;
   assign ws_in   = fr_in + 51'sd8388608;
   assign ns_in   = nfr_in + 51'sd8388608;
   assign whole_in = fr_in[50] ? -$signed({1'b0, ns_in[50:24]}) : $signed({1'b0, ws_in[50:24]});
   assign newfrac_in = fr_in - $signed({whole_in[26:0], 24'd0});

   // position with follow clamp and saturation
   logic signed [33:0] next_in, lo_in, hi_in, c1_in, c2_in;
   logic signed [31:0] pos_in;
   logic               clamp_on;
   assign clamp_on = follow_ff != '0;
   assign next_in  = {{2{pos_ff[31]}}, pos_ff} + {{6{whole_ff[27]}}, whole_ff};
   assign lo_in    = {{2{meas_ff[31]}}, meas_ff} - $signed({10'd0, follow_ff});
   assign hi_in    = {{2{meas_ff[31]}}, meas_ff} + $signed({10'd0, follow_ff});
   assign c1_in    = (clamp_on && next_in < lo_in) ? lo_in : next_in;
   assign c2_in    = (clamp_on && c1_in > hi_in) ? hi_in : c1_in;
   always_comb begin
      if (c2_in > POS_MAX) pos_in = 32'sh7FFF_FFFF;
      else if (c2_in < POS_MIN) pos_in = -32'sh8000_0000;
      else pos_in = c2_in[31:0];
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= MODE_IDLE;
         accel_ff      <= ACCEL_RESET;
         speed_ff      <= SPEED_RESET;
         period_ff     <= PERIOD_RESET;
         follow_ff     <= FOLLOW_RESET;
         pos_ff        <= '0;
         vel_ff        <= '0;
         frac_ff       <= '0;
         goal_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         mul_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         div_start_ff  <= 1'b0;
      end else begin
         mul_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               CSR_ACCEL:  accel_ff  <= csr_data[CFG_WIDTH-1:0];
               CSR_SPEED:  speed_ff  <= csr_data[CFG_WIDTH-1:0];
               CSR_PERIOD: period_ff <= csr_data;
               CSR_FOLLOW: follow_ff <= csr_data[CFG_WIDTH-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DONE;
                  case (req_data.func)
                     FUNC_TICK: begin
                        meas_ff <= req_data.measured_pos;
                        if (mode_ff == MODE_SEEDED) begin
                           pos_ff   <= req_data.measured_pos;
                           mode_ff  <= MODE_ACTIVE;
                           state_ff <= S_DIST;
                        end else if (mode_ff == MODE_IDLE) begin
                           vel_ff  <= '0;
                           frac_ff <= '0;
                        end else begin
                           state_ff <= S_DIST;
                        end
                     end
                     FUNC_RESET: begin
                        goal_ff <= req_data.measured_pos;
                        pos_ff  <= req_data.measured_pos;
                        vel_ff  <= req_data.measured_vel;
                        frac_ff <= '0;
                        mode_ff <= MODE_SEEDED;
                     end
                     FUNC_MOVE: begin
                        goal_ff <= req_data.target_pos;
                        if (mode_ff == MODE_IDLE) mode_ff <= MODE_ACTIVE;
                     end
                     default: ;
                  endcase
               end
            end
            S_DIST: begin
               rev_ff       <= dist_in[57];
               dmag_ff      <= dmag_in;
               v_ff         <= v_in;
               mul_m_ff     <= {32'd0, period_ff};
               mul_b_ff     <= {8'd0, accel_ff};
               mul_start_ff <= 1'b1;
               state_ff     <= S_ADT;
            end
            S_ADT: begin
               if (mul_done) begin
                  h_ff         <= hsum_in[56:25];
                  step_ff      <= ssum_in[56:24];
                  mul_m_ff     <= {32'd0, hsum_in[56:25]};
                  mul_b_ff     <= hsum_in[56:25];
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_H2;
               end
            end
            S_H2: begin
               if (mul_done) begin
                  h2_ff        <= mul_product[63:0];
                  mul_m_ff     <= {7'd0, dmag_ff};
                  mul_b_ff     <= {8'd0, accel_ff};
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_AD;
               end
            end
            S_AD: begin
               if (mul_done) begin
                  if (big_in) begin
                     vstop_ff <= 32'h8000_0000;
                     state_ff <= S_RAMP;
                  end else begin
                     sqrt_x_ff     <= rad_in[63:0];
                     sqrt_start_ff <= 1'b1;
                     state_ff      <= S_SQRT;
                  end
               end
            end
            S_SQRT: begin
               if (sqrt_done) begin
                  vstop_ff <= (s_in[32] || s_in[31]) ? 32'h8000_0000 : s_in[31:0];
                  state_ff <= S_RAMP;
               end
            end
            S_RAMP: begin
               v_ff <= vr_in[33:0];
               if (may_land_in) begin
                  mul_m_ff     <= {32'd0, vr_in[31:0]};
                  mul_b_ff     <= period_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_VDT;
               end else begin
                  land_ff  <= 1'b0;
                  state_ff <= S_OUTV;
               end
            end
            S_VDT: begin
               if (mul_done) begin
                  land_ff  <= land_in;
                  state_ff <= S_OUTV;
                  if (land_in) begin
                     if (period_ff == '0) begin
                        v_ff <= '0;
                     end else begin
                        div_n_ff     <= {dmag_ff[47:0], 16'd0} + {33'd0, period_ff[31:1]};
                        div_start_ff <= 1'b1;
                        state_ff     <= S_DIV;
                     end
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  v_ff     <= $signed({2'd0, div_quotient});
                  state_ff <= S_OUTV;
               end
            end
            S_OUTV: begin
               vel_ff       <= velo_in;
               mul_m_ff     <= {32'd0, abs_in[31:0]};
               mul_b_ff     <= period_ff;
               mul_start_ff <= 1'b1;
               state_ff     <= S_MAG;
            end
            S_MAG: begin
               if (mul_done) begin
                  whole_ff <= whole_in;
                  frac_ff  <= newfrac_in[31:0];
                  state_ff <= S_POS;
               end
            end
            S_POS: begin
               pos_ff <= pos_in;
               if (land_ff && pos_in == goal_ff) mode_ff <= MODE_IDLE;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.cmd_pos <= pos_ff;
                  rsp_ff.cmd_vel <= vel_ff;
                  rsp_ff.moving  <= mode_ff != MODE_IDLE;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_ADT || state_ff == S_H2 || state_ff == S_AD ||
                    state_ff == S_VDT || state_ff == S_MAG))
      else $error("multiplier finished outside a waiting step");

   a_sqrt_done_expected: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == S_SQRT)
      else $error("root finished outside its step");

   a_div_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> (div_n_ff[DIV_N_WIDTH-1:DIV_Q_WIDTH] < period_ff))
      else $error("landing quotient would overflow");

   a_land_speed_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POS && land_ff) |-> !v_ff[33])
      else $error("landing with negative speed");
`endif

endmodule
`default_nettype wire

### rtl/tmp_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module tmp_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tmp_pkg::MUL_M_WIDTH-1:0]  op_m,
   input  logic [tmp_pkg::MUL_B_WIDTH-1:0]  op_b,
   output logic                             done,
   output logic [tmp_pkg::MUL_P_WIDTH-1:0]  product
);
   import tmp_pkg::*;

   localparam int unsigned CNT_W = $clog2(MUL_B_WIDTH);

   logic                   busy_ff;
   logic                   done_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [MUL_M_WIDTH-1:0] m_ff;
   logic [MUL_M_WIDTH-1:0] hi_ff;
   logic [MUL_B_WIDTH-1:0] lo_ff;
   logic [MUL_M_WIDTH:0]   sum_in;

   assign sum_in  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, m_ff} : '0);
   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_B_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         m_ff  <= op_m;
         hi_ff <= '0;
         lo_ff <= op_b;
      end else if (busy_ff) begin
         hi_ff <= sum_in[MUL_M_WIDTH:1];
         lo_ff <= {sum_in[0], lo_ff[MUL_B_WIDTH-1:1]};
      end
   end

endmodule
`default_nettype wire

### rtl/tmp_sqrt.sv
// digit-by-digit integer square root, two radicand bits per cycle
`default_nettype none
module tmp_sqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tmp_pkg::SQRT_IN_WIDTH-1:0]   radicand,
   output logic                                done,
   output logic [tmp_pkg::SQRT_ROOT_WIDTH-1:0] root
);
   import tmp_pkg::*;

   localparam int unsigned RW    = SQRT_ROOT_WIDTH;
   localparam int unsigned CNT_W = $clog2(RW);

   logic                     busy_ff;
   logic                     done_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [SQRT_IN_WIDTH-1:0] x_ff;
   logic [RW+2:0]            rem_ff;
   logic [RW-1:0]            root_ff;
   logic [RW+2:0]            shifted_in;
   logic [RW+2:0]            trial_in;
   logic                     fit_in;

   assign shifted_in = {rem_ff[RW:0], x_ff[SQRT_IN_WIDTH-1 -: 2]};
   assign trial_in   = {1'b0, root_ff, 2'b01};
   assign fit_in     = shifted_in >= trial_in;
   assign done       = done_ff;
   assign root       = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff    <= {x_ff[SQRT_IN_WIDTH-3:0], 2'b00};
         rem_ff  <= fit_in ? shifted_in - trial_in : shifted_in;
         root_ff <= {root_ff[RW-2:0], fit_in};
      end
   end

endmodule
`default_nettype wire

### rtl/tmp_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit
`default_nettype none
module tmp_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tmp_pkg::DIV_N_WIDTH-1:0] dividend,
   input  logic [tmp_pkg::DIV_Q_WIDTH-1:0] divisor,
   output logic                            done,
   output logic [tmp_pkg::DIV_Q_WIDTH-1:0] quotient
);
   import tmp_pkg::*;

   localparam int unsigned QW    = DIV_Q_WIDTH;
   localparam int unsigned CNT_W = $clog2(QW);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [QW-1:0]    d_ff;
   logic [QW-1:0]    rem_ff;
   logic [QW-1:0]    lo_ff;
   logic [QW:0]      trial_in;
   logic             fit_in;

   assign trial_in = {rem_ff, lo_ff[QW-1]};
   assign fit_in   = trial_in >= {1'b0, d_ff};
   assign done     = done_ff;
   assign quotient = lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         d_ff   <= divisor;
         rem_ff <= dividend[DIV_N_WIDTH-1:QW];
         lo_ff  <= dividend[QW-1:0];
      end else if (busy_ff) begin
         rem_ff <= fit_in ? QW'(trial_in - {1'b0, d_ff}) : trial_in[QW-1:0];
         lo_ff  <= {lo_ff[QW-2:0], fit_in};
      end
   end

endmodule
`default_nettype wire

### tb/tb.sv
// self-checking testbench for the trapezoid motion planner unit
`timescale 1ns / 1ps
module tb;
   import tmp_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_ACTIVE = 2'd1;
   localparam logic [1:0] MODE_SEEDED = 2'd2;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   tmp_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   tmp_rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   trapezoid_motion_planner_unit dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // planner copy
   logic [23:0] accel_set, speed_set, follow_set;
   logic [31:0] period_set;
   logic signed [31:0] plan_pos, plan_vel, plan_frac, plan_goal;
   logic [1:0] plan_mode;

   tmp_rsp_type pending_rsp[$];
   int error_count = 0;
   int rsp_count = 0;
   int moving_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycle_count = 0;

   function automatic logic signed [31:0] sat_to_32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] int_root(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void plan_tick(longint meas);
      longint gap, v, vdes, vstop, inc, frac, whole, nxt, sv;
      logic [63:0] d, a, dt, adt, h, stp, rad, dh, dl, t, lo, h2, s, q1, r, mag;
      logic rev, big, land;
      if (plan_mode == MODE_SEEDED) begin
         plan_pos = meas[31:0];
         plan_mode = MODE_ACTIVE;
      end
      if (plan_mode == MODE_IDLE) begin
         plan_vel = 0;
         plan_frac = 0;
         return;
      end
      a = accel_set;
      dt = period_set;
      gap = (longint'(plan_goal) - longint'(plan_pos)) * (64'sd1 <<< 24) - plan_frac;
      rev = gap < 0;
      d = rev ? -gap : gap;
      v = rev ? -longint'(plan_vel) : longint'(plan_vel);
      adt = a * dt;
      h = (adt + (64'd1 << 24)) >> 25;
      stp = (adt + (64'd1 << 23)) >> 24;
      big = 0;
      rad = 0;
      dh = d >> 7;
      dl = d & 64'd127;
      if (dh != 0 && a > (64'hffffffffffffffff / dh)) big = 1;
      else begin
         t = a * dh;
         lo = (a * dl) >> 7;
         h2 = h * h;
         if (t > 64'hffffffffffffffff - lo) big = 1;
         else begin
            t += lo;
            if (t > 64'hffffffffffffffff - h2) big = 1;
            else rad = t + h2;
         end
      end
      vstop = 64'sd1 <<< 31;
      if (!big) begin
         s = int_root(rad) - h;
         if (s < (64'd1 << 31)) vstop = s;
      end
      vdes = longint'(speed_set) * 256;
      if (vdes > vstop) vdes = vstop;
      if (v < vdes) begin
         v += stp;
         if (v > vdes) v = vdes;
      end else begin
         v -= stp;
         if (v < vdes) v = vdes;
      end
      land = v <= vstop && v >= 0 && (((64'(v) * dt) >> 16) >= d);
      if (land) begin
         if (dt == 0) v = 0;
         else begin
            q1 = d / dt;
            r = d % dt;
            v = (q1 << 16) + (((r << 16) + (dt >> 1)) / dt);
         end
      end
      plan_vel = sat_to_32(rev ? -v : v);
      sv = plan_vel;
      mag = 64'(sv < 0 ? -sv : sv) * dt;
      inc = (mag + 64'd32768) >> 16;
      frac = longint'(plan_frac) + (sv < 0 ? -inc : inc);
      if (frac >= 0) whole = (frac + (64'sd1 <<< 23)) >>> 24;
      else whole = -(((-frac) + (64'sd1 <<< 23)) >>> 24);
      frac -= whole * (64'sd1 <<< 24);
      plan_frac = frac[31:0];
      nxt = longint'(plan_pos) + whole;
      if (follow_set != 0) begin
         if (nxt < meas - longint'(follow_set)) nxt = meas - longint'(follow_set);
         if (nxt > meas + longint'(follow_set)) nxt = meas + longint'(follow_set);
      end
      plan_pos = sat_to_32(nxt);
      if (land && plan_pos == plan_goal) plan_mode = MODE_IDLE;
   endfunction

   function automatic tmp_rsp_type plan_item(tmp_req_type it);
      tmp_rsp_type o;
      case (it.func)
         FUNC_TICK: plan_tick(longint'(it.measured_pos));
         FUNC_RESET: begin
            plan_goal = it.measured_pos;
            plan_pos = it.measured_pos;
            plan_vel = it.measured_vel;
            plan_frac = 0;
            plan_mode = MODE_SEEDED;
         end
         FUNC_MOVE: begin
            plan_goal = it.target_pos;
            if (plan_mode == MODE_IDLE) plan_mode = MODE_ACTIVE;
         end
         default: ;
      endcase
      o.cmd_pos = plan_pos;
      o.cmd_vel = plan_vel;
      o.moving = plan_mode != MODE_IDLE;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      tmp_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) report_mismatch("unexpected beat", 0, 0);
            else begin
               want = pending_rsp.pop_front();
               rsp_count++;
               if (rsp_data.moving) moving_count++;
               if (rsp_data.cmd_pos !== want.cmd_pos)
                  report_mismatch("cmd_pos", rsp_data.cmd_pos, want.cmd_pos);
               if (rsp_data.cmd_vel !== want.cmd_vel)
                  report_mismatch("cmd_vel", rsp_data.cmd_vel, want.cmd_vel);
               if (rsp_data.moving !== want.moving)
                  report_mismatch("moving", rsp_data.moving, want.moving);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // valid stays high into the next beat unless the sender idles first
   task automatic send_item(logic [1:0] f, logic [31:0] mp, logic [31:0] mv,
                            logic [31:0] tp);
      tmp_req_type it;
      it.func = f;
      it.measured_pos = mp;
      it.measured_vel = mv;
      it.target_pos = tp;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      pending_rsp.push_back(plan_item(it));
      req_data <= it;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_WIDTH-1:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ACCEL: accel_set = val[23:0];
         CSR_SPEED: speed_set = val[23:0];
         CSR_PERIOD: period_set = val;
         CSR_FOLLOW: follow_set = val[23:0];
         default: ;
      endcase
   endtask

   task automatic set_all(logic [31:0] acc, logic [31:0] spd, logic [31:0] per,
                          logic [31:0] fol);
      drain();
      write_csr(CSR_ACCEL, acc);
      write_csr(CSR_SPEED, spd);
      write_csr(CSR_PERIOD, per);
      write_csr(CSR_FOLLOW, fol);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(200) - 100;
         default: return $urandom_range(20000) - 10000;
      endcase
   endfunction

   task automatic test_directed;
      send_item(FUNC_TICK, 0, 0, 0);
      send_item(FUNC_MOVE, 0, 0, 50);
      repeat (4) send_item(FUNC_TICK, 0, 0, 0);
      send_item(FUNC_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_item(FUNC_RESET, 32'h7fffffff, 32'h7fffffff, 0);
      send_item(FUNC_MOVE, 0, 0, 32'h80000000);
      repeat (3) send_item(FUNC_TICK, 32'h7fffffff, 0, 0);
      send_item(FUNC_RESET, 32'h80000000, 32'h80000000, 32'h7fffffff);
      send_item(FUNC_MOVE, 0, 0, 32'h7fffffff);
      repeat (3) send_item(FUNC_TICK, 32'h80000000, 0, 0);
      send_item(FUNC_RESET, 10, 0, 0);
      send_item(FUNC_MOVE, 0, 0, 11);
      repeat (3) send_item(FUNC_TICK, 10, 0, 0);
   endtask

   task automatic test_settings_extremes;
      set_all(32'hffffff, 32'hffffff, 32'hffffffff, 32'hffffff);
      send_item(FUNC_RESET, 0, 0, 0);
      send_item(FUNC_MOVE, 0, 0, 32'h7fffffff);
      repeat (4) send_item(FUNC_TICK, 0, 0, 0);
      set_all(1, 0, 0, 1);
      send_item(FUNC_RESET, 5, 32'h00001000, 0);
      send_item(FUNC_MOVE, 0, 0, 5);
      repeat (3) send_item(FUNC_TICK, 5, 0, 0);
      set_all(32'(ACCEL_RESET), 32'(SPEED_RESET), PERIOD_RESET, 32'(FOLLOW_RESET));
   endtask

   // mostly move sequences: reseed, set a target, tick a random run, sometimes stopping once arrived
   task automatic test_random_moves(int count);
      int sent;
      int run;
      logic [31:0] meas;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            send_item(2'($urandom_range(3)), $urandom, $urandom, $urandom);
            sent++;
         end else begin
            meas = rand_pos();
            send_item(FUNC_RESET, meas, $urandom_range(1) ? $urandom : 0, 0);
            send_item(FUNC_MOVE, 0, 0, meas + $urandom_range(400) - 200);
            run = $urandom_range(40, 5);
            sent += 2 + run;
            repeat (run) begin
               send_item(FUNC_TICK, plan_pos + $urandom_range(6) - 3, $urandom, $urandom);
               if (plan_mode == MODE_IDLE && $urandom_range(3) == 0) break;
            end
         end
      end
   endtask

   task automatic test_random_settings(int count);
      set_all($urandom_range(1000000, 1000), $urandom_range(50000, 100),
              $urandom_range(4000000, 100000), $urandom_range(1) ? $urandom_range(5) : 0);
      test_random_moves(count);
   endtask

   initial begin
      accel_set = ACCEL_RESET;
      speed_set = SPEED_RESET;
      period_set = PERIOD_RESET;
      follow_set = FOLLOW_RESET;
      plan_pos = 0; plan_vel = 0; plan_frac = 0; plan_goal = 0;
      plan_mode = MODE_IDLE;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_settings_extremes();
      send_idle_pct = 0;  rsp_stall_pct = 0;  test_random_moves(250);
      send_idle_pct = 57; rsp_stall_pct = 0;  test_random_settings(250);
      send_idle_pct = 0;  rsp_stall_pct = 57; test_random_settings(250);
      send_idle_pct = 38; rsp_stall_pct = 38; test_random_settings(250);
      send_idle_pct = 0;  rsp_stall_pct = 0;
      drain();
      $display("covered %0d results (%0d while moving) over directed, extreme", rsp_count,
               moving_count);
      $display("and random settings with sender gaps and receiver stalls");
      if (error_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule
